// ===== rtl/core/grtb_pkg.sv =====
// Shared types and constants for the generation ring topic buffer.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package grtb_pkg;

  localparam int DEFAULT_MAX_DEPTH    = 128;
  localparam int DEFAULT_MESSAGE_BITS = 64;

  // APB register map: register i at byte address 4*i.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_QSIZE_LOG2 = 1'b0;
  localparam logic REG_ADVERTISED = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the input beat
    logic exec;   // slot access and counter update
    logic load;   // move the result into the output register
  } ctrl_t;

endpackage

// ===== rtl/core/grtb_ctrl.sv =====
// Sequencing state machine of the generation ring topic buffer.
// Depends on grtb_pkg; drives the handshakes and the datapath commands.
`timescale 1ns / 1ps

module grtb_ctrl import grtb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        // Wait until the output register is free or is being emptied.
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/grtb_dp.sv =====
// Datapath of the generation ring topic buffer: message store, publish
// counter, configuration registers and result registers. Depends on grtb_pkg.
`timescale 1ns / 1ps

module grtb_dp import grtb_pkg::*; #(
  parameter int MAX_DEPTH    = DEFAULT_MAX_DEPTH,
  parameter int MESSAGE_BITS = DEFAULT_MESSAGE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  logic [1:0]              cmd_i,
  input  logic [MESSAGE_BITS-1:0] write_data_i,
  input  logic [31:0]             reader_generation_i,
  output logic [MESSAGE_BITS-1:0] read_data_o,
  output logic [31:0]             next_generation_o,
  output logic                    ok_o,
  output logic [31:0]             updates_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata
);

  localparam int ADDR_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  // Largest power of two that fits in the store.
  localparam int CAP_LOG2 = $clog2(MAX_DEPTH + 1) - 1;
  localparam logic [2:0] CAP_L = 3'(CAP_LOG2);

  // Configuration registers.
  logic [2:0] qsize_log2_q;
  logic       advertised_q;

  // Topic state.
  logic [31:0]          pcount_q;
  logic                 has_data_q;
  logic [MAX_DEPTH-1:0] slot_vld_q;
  logic [MESSAGE_BITS-1:0] mem_q [MAX_DEPTH];

  // Captured input beat.
  logic [1:0]              cmd_q;
  logic [MESSAGE_BITS-1:0] wdata_q;
  logic [31:0]             rgen_q;
  logic [31:0]             g1_q;
  logic                    inwin_q;

  // Access results waiting for the output register.
  logic [MESSAGE_BITS-1:0] rd_q;
  logic                    rd_vld_q;
  logic                    res_hit_q;
  logic                    res_ok_q;
  logic [31:0]             res_next_q;
  logic [31:0]             res_upd_q;

  // Output register.
  logic [MESSAGE_BITS-1:0] read_data_q;
  logic [31:0]             next_gen_q;
  logic                    ok_q;
  logic [31:0]             updates_q;

  logic [2:0]        eff_log2;
  logic [31:0]       depth;
  logic [ADDR_W-1:0] idx_mask;
  logic [31:0]       gen_sel;
  logic [ADDR_W-1:0] addr;
  logic              cfg_wr;
  logic              is_write;

  assign eff_log2 = (qsize_log2_q > CAP_L) ? CAP_L : qsize_log2_q;
  assign depth    = 32'(1) << eff_log2;
  assign idx_mask = ADDR_W'(depth - 32'd1);

  // A reader outside the held window jumps to the oldest generation.
  assign gen_sel  = inwin_q ? g1_q : (pcount_q - depth);
  assign is_write = (cmd_q == CMD_WRITE);
  assign addr     = is_write ? (pcount_q[ADDR_W-1:0] & idx_mask)
                             : (gen_sel[ADDR_W-1:0] & idx_mask);

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_log2_q <= '0;
      advertised_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_QSIZE_LOG2: begin
          // The depth is frozen after the first message and never shrinks.
          if (!has_data_q && (pwdata[2:0] >= qsize_log2_q)) begin
            qsize_log2_q <= pwdata[2:0];
          end
        end
        REG_ADVERTISED: advertised_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_QSIZE_LOG2: prdata = PDATA_W'(qsize_log2_q);
      REG_ADVERTISED: prdata = PDATA_W'(advertised_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q   <= '0;
      has_data_q <= 1'b0;
      slot_vld_q <= '0;
    end else if (ctrl_i.exec && is_write) begin
      pcount_q         <= pcount_q + 32'd1;
      has_data_q       <= 1'b1;
      slot_vld_q[addr] <= 1'b1;
    end
  end

  // Single-port message store; read data is registered.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      if (is_write) begin
        mem_q[addr] <= wdata_q;
      end
      rd_q     <= mem_q[addr];
      rd_vld_q <= slot_vld_q[addr];
    end
  end

  // Input capture: the step-back and the window test are resolved here.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= cmd_i;
      wdata_q <= write_data_i;
      rgen_q  <= reader_generation_i;
      g1_q    <= (reader_generation_i == pcount_q) ? (pcount_q - 32'd1)
                                                   : reader_generation_i;
      inwin_q <= (reader_generation_i == pcount_q) ||
                 ((pcount_q - 32'd1 - reader_generation_i) < depth);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      res_hit_q  <= 1'b0;
      res_ok_q   <= 1'b0;
      res_next_q <= '0;
      res_upd_q  <= '0;
      case (cmd_q)
        CMD_WRITE: res_ok_q <= 1'b1;
        CMD_READ: begin
          if (!has_data_q) begin
            res_next_q <= rgen_q;
          end else begin
            res_hit_q  <= 1'b1;
            res_ok_q   <= 1'b1;
            res_next_q <= gen_sel + 32'd1;
          end
        end
        CMD_QUERY: begin
          if (advertised_q) begin
            res_upd_q <= pcount_q - rgen_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      // A slot that was never written reads as zero.
      read_data_q <= (res_hit_q && rd_vld_q) ? rd_q : '0;
      next_gen_q  <= res_next_q;
      ok_q        <= res_ok_q;
      updates_q   <= res_upd_q;
    end
  end

  assign read_data_o       = read_data_q;
  assign next_generation_o = next_gen_q;
  assign ok_o              = ok_q;
  assign updates_o         = updates_q;

endmodule

// ===== rtl/core/generation_ring_topic_buffer_top.sv =====
// Generation ring topic buffer: one publisher, many readers by generation.
// A beat passes through capture, store access on the single registered store port
// and result load; no new beat is taken until the last result is loaded, which
// waits while the output register holds a result that has not been taken.
// Reset clears the publish counter, configuration and slot valid bits at once;
// no clearing pass is needed, unwritten slots read as zero.
`timescale 1ns / 1ps

module generation_ring_topic_buffer_top import grtb_pkg::*; #(
  parameter int MAX_DEPTH    = DEFAULT_MAX_DEPTH,
  parameter int MESSAGE_BITS = DEFAULT_MESSAGE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              cmd_i,
  input  logic [MESSAGE_BITS-1:0] write_data_i,
  input  logic [31:0]             reader_generation_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MESSAGE_BITS-1:0] read_data_o,
  output logic [31:0]             next_generation_o,
  output logic                    ok_o,
  output logic [31:0]             updates_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  ctrl_t ctrl;

  assign pready = 1'b1;

  grtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  grtb_dp #(
    .MAX_DEPTH    (MAX_DEPTH),
    .MESSAGE_BITS (MESSAGE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .cmd_i               (cmd_i),
    .write_data_i        (write_data_i),
    .reader_generation_i (reader_generation_i),
    .read_data_o         (read_data_o),
    .next_generation_o   (next_generation_o),
    .ok_o                (ok_o),
    .updates_o           (updates_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata)
  );

endmodule

// ===== rtl/core/grtb_checker.sv =====
// Port-level assertions for the generation ring topic buffer, bound to the
// top level. Depends on grtb_pkg and generation_ring_topic_buffer_top.
`timescale 1ns / 1ps

module grtb_checker import grtb_pkg::*; #(
  parameter int MESSAGE_BITS = DEFAULT_MESSAGE_BITS
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [MESSAGE_BITS-1:0] read_data_o,
  input logic [31:0]             next_generation_o,
  input logic                    ok_o,
  input logic [31:0]             updates_o
);

  // A held result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
      $stable(next_generation_o) && $stable(ok_o) && $stable(updates_o))
    else $error("result beat changed while stalled");

  // One beat is worked on at a time: no new beat right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in flight");

  // A result without ok (a failed read, a query or the unused command) carries no message word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_data_o == '0)
    else $error("message word without ok");

  // A nonzero update count only comes from a query result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && updates_o != 32'd0 |->
      !ok_o && next_generation_o == 32'd0 && read_data_o == '0)
    else $error("update count mixed with read or write result");

endmodule

bind generation_ring_topic_buffer_top grtb_checker #(
  .MESSAGE_BITS (MESSAGE_BITS)
) u_grtb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .read_data_o       (read_data_o),
  .next_generation_o (next_generation_o),
  .ok_o              (ok_o),
  .updates_o         (updates_o)
);

// ===== tb/grtb_result_checker.sv =====
// Result checker for the generation ring topic buffer.
// It watches the input, output and APB channels, models the ring and compares each result beat.
// Depends on grtb_pkg for the command codes and the register map.
`timescale 1ns / 1ps

module grtb_result_checker import grtb_pkg::*; #(
  parameter int MAX_DEPTH    = DEFAULT_MAX_DEPTH,
  parameter int MESSAGE_BITS = DEFAULT_MESSAGE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              cmd_i,
  input  logic [MESSAGE_BITS-1:0] write_data_i,
  input  logic [31:0]             reader_generation_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [MESSAGE_BITS-1:0] read_data_i,
  input  logic [31:0]             next_generation_i,
  input  logic                    ok_i,
  input  logic [31:0]             updates_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [PADDR_W-1:0]      paddr_i,
  input  logic [PDATA_W-1:0]      pwdata_i,
  input  logic                    pready_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [MESSAGE_BITS-1:0] read_data;
    logic [31:0]             next_generation;
    logic                    ok;
    logic [31:0]             updates;
  } ring_result_t;

  logic [MESSAGE_BITS-1:0] ring_slots [MAX_DEPTH];
  logic [31:0]             publish_count;
  logic                    has_data;
  logic [2:0]              depth_log2;
  logic                    advertised;

  ring_result_t            expected_results [$];
  ring_result_t            oldest_result;
  int                      mismatches;

  // Window test that survives the generation counter wrapping.
  function automatic bit gen_in_window(input logic [31:0] lo, input logic [31:0] v,
                                       input logic [31:0] hi);
    if (hi > lo) return (lo <= v) && (v <= hi);
    return (lo <= v) || (v <= hi);
  endfunction

  function automatic ring_result_t predict_ring_access(input logic [1:0] op,
                                                       input logic [MESSAGE_BITS-1:0] wdata,
                                                       input logic [31:0] rgen);
    ring_result_t res;
    logic [31:0]  depth;
    logic [31:0]  mask;
    logic [31:0]  gen;
    logic [31:0]  oldest;
    res   = '0;
    depth = 32'd1 << depth_log2;
    if (depth > MAX_DEPTH) depth = MAX_DEPTH;
    mask  = depth - 32'd1;
    case (op)
      CMD_WRITE: begin
        ring_slots[publish_count & mask] = wdata;
        publish_count = publish_count + 32'd1;
        has_data = 1'b1;
        res.ok = 1'b1;
      end
      CMD_READ: begin
        if (!has_data) begin
          res.next_generation = rgen;
        end else if (depth == 32'd1) begin
          res.read_data       = ring_slots[0];
          res.next_generation = publish_count;
          res.ok              = 1'b1;
        end else begin
          gen    = rgen;
          oldest = publish_count - depth;
          // An up-to-date reader gets the latest message again.
          if (gen == publish_count) gen = gen - 32'd1;
          if (!gen_in_window(oldest, gen, publish_count - 32'd1)) gen = oldest;
          res.read_data       = ring_slots[gen & mask];
          res.next_generation = gen + 32'd1;
          res.ok              = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (advertised) res.updates = publish_count - rgen;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DEPTH; i++) ring_slots[i] = '0;
      publish_count = '0;
      has_data      = 1'b0;
      depth_log2    = '0;
      advertised    = 1'b0;
      mismatches    = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {REG_QSIZE_LOG2, 2'b00}) begin
          // The depth is frozen once data is stored and may never shrink.
          if (!has_data && pwdata_i[2:0] >= depth_log2) depth_log2 = pwdata_i[2:0];
        end else if (paddr_i == {REG_ADVERTISED, 2'b00}) begin
          advertised = pwdata_i[0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_ring_access(cmd_i, write_data_i,
                                                       reader_generation_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no result outstanding");
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (read_data_i !== oldest_result.read_data) begin
            $error("read_data: expected %h, actual %h", oldest_result.read_data, read_data_i);
            mismatches++;
          end
          if (next_generation_i !== oldest_result.next_generation) begin
            $error("next_generation: expected %h, actual %h",
                   oldest_result.next_generation, next_generation_i);
            mismatches++;
          end
          if (ok_i !== oldest_result.ok) begin
            $error("ok: expected %b, actual %b", oldest_result.ok, ok_i);
            mismatches++;
          end
          if (updates_i !== oldest_result.updates) begin
            $error("updates: expected %h, actual %h", oldest_result.updates, updates_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// ===== tb/generation_ring_topic_buffer_top_tb.sv =====
// Testbench top for the generation ring topic buffer: clock, reset, stimulus and verdict.
// Depends on grtb_pkg, generation_ring_topic_buffer_top and grtb_result_checker.
`timescale 1ns / 1ps

module generation_ring_topic_buffer_top_tb;
  import grtb_pkg::*;

  localparam logic [1:0]         CMD_UNUSED     = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_QSIZE     = {REG_QSIZE_LOG2, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_ADVERTISE = {REG_ADVERTISED, 2'b00};
  localparam int                 QUIET_LIMIT    = 2000;
  localparam int                 PHASE_BEATS    = 420;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          cmd_i;
  logic [63:0]         write_data_i;
  logic [31:0]         reader_generation_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [63:0]         read_data_o;
  logic [31:0]         next_generation_o;
  logic                ok_o;
  logic [31:0]         updates_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int                  fail_count;
  int                  pending;
  logic                idling;
  logic [31:0]         writes_sent;
  int unsigned         ring_log2;
  logic [31:0]         ring_depth;

  generation_ring_topic_buffer_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .write_data_i, .reader_generation_i,
    .out_valid_o, .out_ready_i, .read_data_o, .next_generation_o, .ok_o, .updates_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  grtb_result_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .cmd_i               (cmd_i),
    .write_data_i        (write_data_i),
    .reader_generation_i (reader_generation_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_data_i         (read_data_o),
    .next_generation_i   (next_generation_o),
    .ok_i                (ok_o),
    .updates_i           (updates_o),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .pready_i            (pready),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Holds valid and payload until the beat is taken; valid is lowered only before a gap.
  task automatic send_beat(input logic [1:0] op, input logic [63:0] wdata,
                           input logic [31:0] rgen);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    cmd_i               <= op;
    write_data_i        <= wdata;
    reader_generation_i <= rgen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == CMD_WRITE) writes_sent = writes_sent + 32'd1;
  endtask

  // Leaves the block idle: no beat in flight and every result delivered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Readers mostly sit near the publisher, inside or just outside the window.
  task automatic random_beat();
    logic [1:0]  op;
    logic [31:0] rgen;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = CMD_WRITE;
    else if (pick < 75) op = CMD_READ;
    else if (pick < 95) op = CMD_QUERY;
    else                op = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 6)       rgen = writes_sent - $urandom_range(0, 2 * ring_depth + 1);
    else if (pick == 6) rgen = writes_sent;
    else if (pick == 7) rgen = writes_sent + $urandom_range(1, 40);
    else                rgen = $urandom;
    send_beat(op, {$urandom, $urandom}, rgen);
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("generation_ring_topic_buffer_top verification failed");
    $finish;
  end

  initial begin
    int unsigned pick;
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    cmd_i               = CMD_WRITE;
    write_data_i        = '0;
    reader_generation_i = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    idling              = 1'b0;
    writes_sent         = '0;
    // The depth locks at the first write, so each run settles on one; extremes weigh more.
    pick       = $urandom_range(0, 9);
    ring_log2  = (pick == 8) ? 0 : (pick == 9) ? 7 : pick;
    ring_depth = 32'd1 << ring_log2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads and queries on an empty, unadvertised topic, and the unused command.
    send_beat(CMD_READ, 64'h0, 32'h0);
    send_beat(CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_QUERY, 64'h0, 32'd5);
    send_beat(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();
    apb_write_reg(ADDR_ADVERTISE, 32'd1);
    apb_write_reg(ADDR_QSIZE, 32'd0);
    apb_write_reg(ADDR_QSIZE, ring_log2);
    apb_write_reg(ADDR_QSIZE, 32'd0);
    send_beat(CMD_QUERY, 64'h0, 32'h0);
    send_beat(CMD_QUERY, 64'h0, 32'hFFFF_FFFF);
    send_beat(CMD_WRITE, 64'h0, 32'h0);
    send_beat(CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_WRITE, 64'hA5A5_5A5A_F0F0_0F0F, 32'h0);
    send_beat(CMD_READ, 64'h0, writes_sent);
    send_beat(CMD_READ, 64'h0, writes_sent + 32'd500);
    send_beat(CMD_READ, 64'h0, 32'h0);
    send_beat(CMD_READ, 64'h0, 32'hFFFF_FFFF);
    send_beat(CMD_WRITE, {$urandom, $urandom}, $urandom);
    send_beat(CMD_READ, 64'h0, writes_sent - 32'd1);
    send_beat(CMD_READ, 64'h0, writes_sent - ring_depth);
    send_beat(CMD_QUERY, 64'h0, writes_sent);
    send_beat(CMD_UNUSED, 64'h0, 32'h0);
    drain_results();
    // Depth writes are ignored now that the ring holds data.
    apb_write_reg(ADDR_QSIZE, 32'd7);
    apb_write_reg(ADDR_ADVERTISE, 32'd0);
    send_beat(CMD_QUERY, 64'h0, 32'd3);
    send_beat(CMD_READ, 64'h0, writes_sent);
    drain_results();
    apb_write_reg(ADDR_ADVERTISE, 32'd1);

    for (int phase = 0; phase < 4; phase++) begin
      idling = (phase == 0 || phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) random_beat();
      drain_results();
      apb_write_reg(ADDR_QSIZE, $urandom_range(0, 7));
      apb_write_reg(ADDR_ADVERTISE, phase % 2);
    end
    idling = 1'b0;
    for (int n = 0; n < 40; n++) random_beat();
    drain_results();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("generation_ring_topic_buffer_top verification clean");
    end else begin
      $display("generation_ring_topic_buffer_top verification failed");
    end
    $finish;
  end

endmodule
